FILE: hdl/flr_pkg.sv
package flr_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned CAP_DEPTH      = 7;
  localparam int unsigned CAP_IDX_W      = 3;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned DATA_W         = 32;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [7:0]  CMD_TYPE_RST     = 8'd1;
  localparam logic [7:0]  HB_TYPE_RST      = 8'd2;
  localparam logic [7:0]  HB_SRC_RST       = 8'd2;
  localparam logic [7:0]  MAX_LEN_RST      = 8'd64;
  localparam logic [31:0] CMD_TIMEOUT_RST  = 32'd500;
  localparam logic [31:0] LINK_TIMEOUT_RST = 32'd1000;

  typedef enum logic [3:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_VER,
    PH_TYPE,
    PH_LEN,
    PH_SEQ,
    PH_PAY,
    PH_CRCL,
    PH_CRCH
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_CMD,
    EV_HB,
    EV_OTHER,
    EV_CRC,
    EV_LEN
  } ev_t;

  typedef enum logic [2:0] {
    REG_CMD_TYPE,
    REG_HB_TYPE,
    REG_HB_SRC,
    REG_MAX_LEN,
    REG_CMD_TIMEOUT,
    REG_LINK_TIMEOUT
  } reg_idx_t;

  typedef logic [CAP_DEPTH-1:0][7:0] cap_t;

  typedef struct packed {
    logic [7:0]  cmd_type;
    logic [7:0]  hb_type;
    logic [7:0]  hb_src;
    logic [7:0]  max_len;
    logic [31:0] cmd_timeout;
    logic [31:0] link_timeout;
  } cfg_t;

  // Outcome of the second CRC byte of a frame.
  typedef struct packed {
    logic       good;
    logic [7:0] seq;
    logic       is_cmd;
    logic       link_refresh;
  } frame_done_t;

  typedef struct packed {
    ev_t         ev;
    cap_t        cmd;
    logic [15:0] lost;
    logic        cmd_fresh;
    logic        link_fresh;
  } out_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/flr_cfg_regs.sv
module flr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flr_pkg::ADDR_W-1:0]   paddr,
  input  logic [flr_pkg::DATA_W-1:0]   pwdata,
  output logic [flr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output flr_pkg::cfg_t                cfg
);

  flr_pkg::cfg_t     cfg_r;
  flr_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = flr_pkg::reg_idx_t'(paddr[flr_pkg::ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_type     <= flr_pkg::CMD_TYPE_RST;
      cfg_r.hb_type      <= flr_pkg::HB_TYPE_RST;
      cfg_r.hb_src       <= flr_pkg::HB_SRC_RST;
      cfg_r.max_len      <= flr_pkg::MAX_LEN_RST;
      cfg_r.cmd_timeout  <= flr_pkg::CMD_TIMEOUT_RST;
      cfg_r.link_timeout <= flr_pkg::LINK_TIMEOUT_RST;
    end else if (wr) begin
      case (idx)
        flr_pkg::REG_CMD_TYPE:     cfg_r.cmd_type     <= pwdata[7:0];
        flr_pkg::REG_HB_TYPE:      cfg_r.hb_type      <= pwdata[7:0];
        flr_pkg::REG_HB_SRC:       cfg_r.hb_src       <= pwdata[7:0];
        flr_pkg::REG_MAX_LEN:      cfg_r.max_len      <= pwdata[7:0];
        flr_pkg::REG_CMD_TIMEOUT:  cfg_r.cmd_timeout  <= pwdata;
        flr_pkg::REG_LINK_TIMEOUT: cfg_r.link_timeout <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      flr_pkg::REG_CMD_TYPE:     prdata = {24'd0, cfg_r.cmd_type};
      flr_pkg::REG_HB_TYPE:      prdata = {24'd0, cfg_r.hb_type};
      flr_pkg::REG_HB_SRC:       prdata = {24'd0, cfg_r.hb_src};
      flr_pkg::REG_MAX_LEN:      prdata = {24'd0, cfg_r.max_len};
      flr_pkg::REG_CMD_TIMEOUT:  prdata = cfg_r.cmd_timeout;
      flr_pkg::REG_LINK_TIMEOUT: prdata = cfg_r.link_timeout;
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: hdl/flr_deframer.sv
module flr_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  input  flr_pkg::cfg_t        cfg,
  output flr_pkg::ev_t         ev,
  output flr_pkg::frame_done_t done,
  output flr_pkg::cap_t        cap
);

  flr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      idx_r, idx_nxt;
  logic [7:0]      seq_r, seq_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;
  flr_pkg::cap_t   cap_r;

  logic [15:0]     crc_upd;
  logic [7:0]      idx_inc;
  logic            is_cmd, is_hb, crc_ok;
  flr_pkg::ev_t    ev_raw;

  assign crc_upd = flr_pkg::crc16_byte((phase_r == flr_pkg::PH_VER) ? flr_pkg::CRC_INIT : crc_r,
                                       rx_byte);
  assign idx_inc = idx_r + 8'd1;
  assign crc_ok  = ({rx_byte, crc_lo_r} == crc_r);

  // Classify from header fields; a short command frame falls through to the heartbeat check.
  assign is_cmd = (type_r == cfg.cmd_type) && (len_r >= 8'(flr_pkg::CAP_DEPTH));
  assign is_hb  = (type_r == cfg.hb_type) && (len_r != 8'd0);

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    seq_nxt    = seq_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    ev_raw     = flr_pkg::EV_NONE;
    case (phase_r)
      flr_pkg::PH_HUNT0: begin
        if (rx_byte == flr_pkg::SYNC_FIRST) phase_nxt = flr_pkg::PH_HUNT1;
      end
      flr_pkg::PH_HUNT1: begin
        if (rx_byte == flr_pkg::SYNC_SECOND) phase_nxt = flr_pkg::PH_VER;
        else if (rx_byte != flr_pkg::SYNC_FIRST) phase_nxt = flr_pkg::PH_HUNT0;
      end
      flr_pkg::PH_VER: begin
        crc_nxt   = crc_upd;
        phase_nxt = flr_pkg::PH_TYPE;
      end
      flr_pkg::PH_TYPE: begin
        type_nxt  = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = flr_pkg::PH_LEN;
      end
      flr_pkg::PH_LEN: begin
        if (rx_byte > cfg.max_len) begin
          phase_nxt = flr_pkg::PH_HUNT0;
          ev_raw    = flr_pkg::EV_LEN;
        end else begin
          len_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = flr_pkg::PH_SEQ;
        end
      end
      flr_pkg::PH_SEQ: begin
        seq_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        idx_nxt   = 8'd0;
        phase_nxt = (len_r != 8'd0) ? flr_pkg::PH_PAY : flr_pkg::PH_CRCL;
      end
      flr_pkg::PH_PAY: begin
        crc_nxt = crc_upd;
        idx_nxt = idx_inc;
        if (idx_inc >= len_r) phase_nxt = flr_pkg::PH_CRCL;
      end
      flr_pkg::PH_CRCL: begin
        crc_lo_nxt = rx_byte;
        phase_nxt  = flr_pkg::PH_CRCH;
      end
      flr_pkg::PH_CRCH: begin
        phase_nxt = flr_pkg::PH_HUNT0;
        if (!crc_ok)     ev_raw = flr_pkg::EV_CRC;
        else if (is_cmd) ev_raw = flr_pkg::EV_CMD;
        else if (is_hb)  ev_raw = flr_pkg::EV_HB;
        else             ev_raw = flr_pkg::EV_OTHER;
      end
      default: begin
        phase_nxt = flr_pkg::PH_HUNT0;
      end
    endcase
  end

  assign ev                = take ? ev_raw : flr_pkg::EV_NONE;
  assign done.good         = take && (phase_r == flr_pkg::PH_CRCH) && crc_ok;
  assign done.seq          = seq_r;
  assign done.is_cmd       = is_cmd;
  assign done.link_refresh = is_cmd || (is_hb && (cap_r[0] == cfg.hb_src));
  assign cap               = cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= flr_pkg::PH_HUNT0;
      type_r   <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      seq_r    <= '0;
      crc_r    <= flr_pkg::CRC_INIT;
      crc_lo_r <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      seq_r    <= seq_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Keep the first payload bytes; later bytes only feed the CRC.
  always_ff @(posedge clk) begin
    if (take && (phase_r == flr_pkg::PH_PAY) && (idx_r < 8'(flr_pkg::CAP_DEPTH))) begin
      cap_r[idx_r[flr_pkg::CAP_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

FILE: hdl/flr_link_state.sv
module flr_link_state #(
  parameter int unsigned TIME_WIDTH = flr_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  flr_pkg::frame_done_t  done,
  input  flr_pkg::cap_t         cap,
  input  logic [TIME_WIDTH-1:0] now_t,
  input  flr_pkg::cfg_t         cfg,
  output flr_pkg::cap_t         cmd,
  output logic [15:0]           lost,
  output logic                  cmd_fresh,
  output logic                  link_fresh
);

  logic                  seq_seen_r, seq_seen_nxt;
  logic [7:0]            last_seq_r, last_seq_nxt;
  logic [15:0]           lost_r, lost_nxt;
  flr_pkg::cap_t         cmd_r, cmd_nxt;
  logic [TIME_WIDTH-1:0] cmd_time_r, cmd_time_nxt;
  logic                  cmd_taken_r, cmd_taken_nxt;
  logic [TIME_WIDTH-1:0] link_time_r, link_time_nxt;
  logic                  link_seen_r, link_seen_nxt;

  logic [7:0]            delta;
  logic [TIME_WIDTH-1:0] cmd_age, link_age;

  assign delta = done.seq - last_seq_r;

  always_comb begin
    seq_seen_nxt  = seq_seen_r;
    last_seq_nxt  = last_seq_r;
    lost_nxt      = lost_r;
    cmd_nxt       = cmd_r;
    cmd_time_nxt  = cmd_time_r;
    cmd_taken_nxt = cmd_taken_r;
    link_time_nxt = link_time_r;
    link_seen_nxt = link_seen_r;
    if (done.good) begin
      if (seq_seen_r && (delta > 8'd1)) lost_nxt = lost_r + {8'd0, delta} - 16'd1;
      last_seq_nxt = done.seq;
      seq_seen_nxt = 1'b1;
      if (done.is_cmd) begin
        cmd_nxt       = cap;
        cmd_time_nxt  = now_t;
        cmd_taken_nxt = 1'b1;
      end
      if (done.link_refresh) begin
        link_time_nxt = now_t;
        link_seen_nxt = 1'b1;
      end
    end
  end

  // Judge freshness after this byte has been taken.
  assign cmd_age    = now_t - cmd_time_nxt;
  assign link_age   = now_t - link_time_nxt;
  assign cmd_fresh  = cmd_taken_nxt && (32'(cmd_age) < cfg.cmd_timeout);
  assign link_fresh = link_seen_nxt && (32'(link_age) < cfg.link_timeout);
  assign cmd        = cmd_nxt;
  assign lost       = lost_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_seen_r  <= 1'b0;
      last_seq_r  <= '0;
      lost_r      <= '0;
      cmd_r       <= '0;
      cmd_time_r  <= '0;
      cmd_taken_r <= 1'b0;
      link_time_r <= '0;
      link_seen_r <= 1'b0;
    end else begin
      seq_seen_r  <= seq_seen_nxt;
      last_seq_r  <= last_seq_nxt;
      lost_r      <= lost_nxt;
      cmd_r       <= cmd_nxt;
      cmd_time_r  <= cmd_time_nxt;
      cmd_taken_r <= cmd_taken_nxt;
      link_time_r <= link_time_nxt;
      link_seen_r <= link_seen_nxt;
    end
  end

endmodule

FILE: hdl/framed_link_receiver.sv
// Byte-wise receiver for a sync-headed framed link with CRC-16/CCITT-FALSE.
// Input channel (in_valid/in_stall): one transfer per received byte, with
// in_mode, in_rx_byte and in_now_ms. in_mode 1 is a freshness query only;
// the byte is ignored and no state changes.
// Output channel (out_valid/out_stall): exactly one result transfer per input
// transfer, in order: frame event, the seven latched command bytes, the
// sequence-gap loss count and the command and link freshness flags.
// The result is registered: out_valid rises in the cycle after an input
// transfer; throughput is one item per cycle while out_stall is low, set by
// the single pass through the parser, the CRC byte update and the age
// compares between the parser state and the result register.
// When the receiver stalls, the result register holds its transfer and
// in_stall rises in the same cycle; it drops as soon as the result is taken,
// so a new byte may enter in the cycle the old result leaves.
// Reset (rst_n low, synchronous): parser back to sync hunt, CRC to 0xFFFF,
// loss count, command bytes and freshness history cleared, registers to
// their defaults, output empty. No clearing pass is needed.
// Configuration uses an APB-style port, one 32-bit register per word;
// write it only while no item is in flight.
module framed_link_receiver #(
  parameter int unsigned TIME_WIDTH = flr_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [7:0]                 in_rx_byte,
  input  logic [31:0]                in_now_ms,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_frame_event,
  output logic signed [7:0]          out_left_target,
  output logic signed [7:0]          out_right_target,
  output logic [7:0]                 out_pan_target,
  output logic [7:0]                 out_tilt_target,
  output logic [7:0]                 out_laser_command,
  output logic [7:0]                 out_mode_command,
  output logic [7:0]                 out_flag_bits,
  output logic [15:0]                out_lost_frames,
  output logic                       out_command_fresh,
  output logic                       out_link_fresh,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [flr_pkg::ADDR_W-1:0] paddr,
  input  logic [flr_pkg::DATA_W-1:0] pwdata,
  output logic [flr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  flr_pkg::cfg_t        cfg;
  flr_pkg::ev_t         ev;
  flr_pkg::frame_done_t done;
  flr_pkg::cap_t        cap;
  flr_pkg::out_t        res, out_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_xfer, take;

  // Accept while the result register is empty or is being drained.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign take     = in_xfer & ~in_mode;

  flr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  flr_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .ev      (ev),
    .done    (done),
    .cap     (cap)
  );

  flr_link_state #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_link (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .cap        (cap),
    .now_t      (in_now_ms[TIME_WIDTH-1:0]),
    .cfg        (cfg),
    .cmd        (res.cmd),
    .lost       (res.lost),
    .cmd_fresh  (res.cmd_fresh),
    .link_fresh (res.link_fresh)
  );

  assign res.ev = ev;

  // Hold the result while the receiver stalls; load on every input transfer.
  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_event   = out_r.ev;
  assign out_left_target   = $signed(out_r.cmd[0]);
  assign out_right_target  = $signed(out_r.cmd[1]);
  assign out_pan_target    = out_r.cmd[2];
  assign out_tilt_target   = out_r.cmd[3];
  assign out_laser_command = out_r.cmd[4];
  assign out_mode_command  = out_r.cmd[5];
  assign out_flag_bits     = out_r.cmd[6];
  assign out_lost_frames   = out_r.lost;
  assign out_command_fresh = out_r.cmd_fresh;
  assign out_link_fresh    = out_r.link_fresh;

endmodule

FILE: hdl/flr_checker.sv
module flr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_frame_event,
  input logic [15:0] out_lost_frames
);

  // Every input transfer yields a result on the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after input transfer");

  // A query item never reports a frame event.
  a_query_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> out_frame_event == 3'(flr_pkg::EV_NONE))
    else $error("query item reported a frame event");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_event <= 3'(flr_pkg::EV_LEN))
    else $error("frame event code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_event)
                               && $stable(out_lost_frames))
    else $error("stalled result changed");

endmodule

bind framed_link_receiver flr_checker u_flr_checker (.*);

FILE: tb/framed_link_receiver_tb.sv
module framed_link_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run-length knobs
  localparam int unsigned PHASE_COUNT      = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 230;
  localparam int unsigned LONG_HOLD_CYCLES = 160;
  localparam int unsigned LONG_HOLD_AFTER  = 500;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;

  // One byte transfer on the input channel
  typedef struct packed {
    logic        mode;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } rx_item_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        in_mode    = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [31:0] in_now_ms  = 32'h0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_frame_event;
  logic signed [7:0] out_left_target;
  logic signed [7:0] out_right_target;
  logic [7:0]        out_pan_target;
  logic [7:0]        out_tilt_target;
  logic [7:0]        out_laser_command;
  logic [7:0]        out_mode_command;
  logic [7:0]        out_flag_bits;
  logic [15:0]       out_lost_frames;
  logic              out_command_fresh;
  logic              out_link_fresh;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [flr_pkg::ADDR_W-1:0] paddr   = '0;
  logic [flr_pkg::DATA_W-1:0] pwdata  = '0;
  logic [flr_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  framed_link_receiver i_dut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the register file and the parser state
  // ---------------------------------------------------------------------------
  flr_pkg::cfg_t link_cfg = '{cmd_type: flr_pkg::CMD_TYPE_RST,
                              hb_type: flr_pkg::HB_TYPE_RST,
                              hb_src: flr_pkg::HB_SRC_RST,
                              max_len: flr_pkg::MAX_LEN_RST,
                              cmd_timeout: flr_pkg::CMD_TIMEOUT_RST,
                              link_timeout: flr_pkg::LINK_TIMEOUT_RST};

  flr_pkg::phase_t parse_st   = flr_pkg::PH_HUNT0;
  logic [7:0]      hdr_type   = 8'h00;
  logic [7:0]      hdr_len    = 8'h00;
  logic [7:0]      pay_pos    = 8'h00;
  logic [7:0]      hdr_seq    = 8'h00;
  logic [15:0]     fcs_run    = flr_pkg::CRC_INIT;
  logic [7:0]      fcs_lo     = 8'h00;
  flr_pkg::cap_t   pay_head   = '0;
  logic            seq_known  = 1'b0;
  logic [7:0]      prev_seq   = 8'h00;
  logic [15:0]     lost_total = 16'h0;
  flr_pkg::cap_t   cmd_latch  = '0;
  logic [31:0]     cmd_stamp  = 32'h0;
  logic            cmd_seen   = 1'b0;
  logic [31:0]     link_stamp = 32'h0;
  logic            link_up    = 1'b0;

  // CRC-16/CCITT-FALSE, one input bit per step, MSB first
  function automatic logic [15:0] fcs_update(logic [15:0] fcs, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = fcs[15] ^ b[k];
      fcs = {fcs[14:0], 1'b0} ^ (fb ? flr_pkg::CRC_POLY : 16'h0000);
    end
    return fcs;
  endfunction

  // Take one transfer into the parser model and return the report it produces
  function automatic flr_pkg::out_t advance_deframer(rx_item_t it);
    flr_pkg::out_t r;
    logic [7:0]    b;
    logic [7:0]    seq_gap;
    logic [31:0]   age;
    b    = it.rx_byte;
    r    = '0;
    r.ev = flr_pkg::EV_NONE;
    if (it.mode == 1'b0) begin
      case (parse_st)
        flr_pkg::PH_HUNT0: begin
          if (b == flr_pkg::SYNC_FIRST) parse_st = flr_pkg::PH_HUNT1;
        end
        flr_pkg::PH_HUNT1: begin
          // a second AA keeps waiting for 55
          if (b == flr_pkg::SYNC_SECOND) parse_st = flr_pkg::PH_VER;
          else if (b != flr_pkg::SYNC_FIRST) parse_st = flr_pkg::PH_HUNT0;
        end
        flr_pkg::PH_VER: begin
          fcs_run  = fcs_update(flr_pkg::CRC_INIT, b);
          parse_st = flr_pkg::PH_TYPE;
        end
        flr_pkg::PH_TYPE: begin
          hdr_type = b;
          fcs_run  = fcs_update(fcs_run, b);
          parse_st = flr_pkg::PH_LEN;
        end
        flr_pkg::PH_LEN: begin
          if (b > link_cfg.max_len) begin
            r.ev     = flr_pkg::EV_LEN;
            parse_st = flr_pkg::PH_HUNT0;
          end else begin
            hdr_len  = b;
            fcs_run  = fcs_update(fcs_run, b);
            parse_st = flr_pkg::PH_SEQ;
          end
        end
        flr_pkg::PH_SEQ: begin
          hdr_seq  = b;
          fcs_run  = fcs_update(fcs_run, b);
          pay_pos  = 8'h00;
          parse_st = (hdr_len != 8'h00) ? flr_pkg::PH_PAY : flr_pkg::PH_CRCL;
        end
        flr_pkg::PH_PAY: begin
          if (pay_pos < flr_pkg::CAP_DEPTH) pay_head[pay_pos[2:0]] = b;
          fcs_run = fcs_update(fcs_run, b);
          pay_pos = pay_pos + 8'd1;
          if (pay_pos >= hdr_len) parse_st = flr_pkg::PH_CRCL;
        end
        flr_pkg::PH_CRCL: begin
          fcs_lo   = b;
          parse_st = flr_pkg::PH_CRCH;
        end
        flr_pkg::PH_CRCH: begin
          if ({b, fcs_lo} != fcs_run) begin
            r.ev = flr_pkg::EV_CRC;
          end else begin
            // sequence bookkeeping comes first for every good frame
            seq_gap = hdr_seq - prev_seq;
            if (seq_known && seq_gap > 8'd1) lost_total = lost_total + 16'(seq_gap) - 16'd1;
            prev_seq  = hdr_seq;
            seq_known = 1'b1;
            if (hdr_type == link_cfg.cmd_type && hdr_len >= flr_pkg::CAP_DEPTH) begin
              cmd_latch  = pay_head;
              cmd_stamp  = it.now_ms;
              cmd_seen   = 1'b1;
              link_stamp = it.now_ms;
              link_up    = 1'b1;
              r.ev       = flr_pkg::EV_CMD;
            end else if (hdr_type == link_cfg.hb_type && hdr_len != 8'h00) begin
              if (pay_head[0] == link_cfg.hb_src) begin
                link_stamp = it.now_ms;
                link_up    = 1'b1;
              end
              r.ev = flr_pkg::EV_HB;
            end else begin
              r.ev = flr_pkg::EV_OTHER;
            end
          end
          parse_st = flr_pkg::PH_HUNT0;
        end
        default: parse_st = flr_pkg::PH_HUNT0;
      endcase
    end
    r.cmd  = cmd_latch;
    r.lost = lost_total;
    age    = it.now_ms - cmd_stamp;
    r.cmd_fresh  = cmd_seen && (age < link_cfg.cmd_timeout);
    age    = it.now_ms - link_stamp;
    r.link_fresh = link_up && (age < link_cfg.link_timeout);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state between the stimulus, the driver and the monitor
  // ---------------------------------------------------------------------------
  rx_item_t      rx_backlog[$];
  flr_pkg::out_t expected_reports[$];
  int unsigned   items_queued  = 0;
  int unsigned   reports_taken = 0;
  int unsigned   mismatches    = 0;

  int unsigned send_idle_pct = 20;
  int unsigned stall_pct     = 20;
  bit          tail_quiet    = 1'b0;

  logic [31:0] ms_now    = 32'h0;
  bit          ms_wander = 1'b0;
  logic [7:0]  tx_seq    = 8'h00;

  string cmd_field_names[flr_pkg::CAP_DEPTH] = '{"left_target", "right_target", "pan_target",
                                                 "tilt_target", "laser_command",
                                                 "mode_command", "flag_bits"};

  // ---------------------------------------------------------------------------
  // Driver: present backlog items, hold each payload until its transfer
  // ---------------------------------------------------------------------------
  rx_item_t    on_wire;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // score the transfer that completes at this edge
      if (in_valid && !in_stall) expected_reports.push_back(advance_deframer(on_wire));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!tail_quiet && rx_backlog.size() != 0 &&
                     $urandom_range(99) < send_idle_pct) begin
          // open an idle burst
          send_gap = $urandom_range(10);
          in_valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          on_wire = rx_backlog.pop_front();
          in_valid   <= 1'b1;
          in_mode    <= on_wire.mode;
          in_rx_byte <= on_wire.rx_byte;
          in_now_ms  <= on_wire.now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer, drive out_stall
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  flr_pkg::out_t want_rep;
  flr_pkg::out_t got_rep;
  int unsigned   stall_gap      = 0;
  int unsigned   hold_left      = 0;
  bit            long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reports_taken++;
        if (expected_reports.size() == 0) begin
          $error("result transfer with no expected report pending");
          mismatches++;
        end else begin
          want_rep = expected_reports.pop_front();
          got_rep.ev   = flr_pkg::ev_t'(out_frame_event);
          got_rep.cmd  = {out_flag_bits, out_mode_command, out_laser_command, out_tilt_target,
                          out_pan_target, out_right_target, out_left_target};
          got_rep.lost = out_lost_frames;
          got_rep.cmd_fresh  = out_command_fresh;
          got_rep.link_fresh = out_link_fresh;
          check_field("frame_event", want_rep.ev, got_rep.ev);
          for (int k = 0; k < flr_pkg::CAP_DEPTH; k++) begin
            check_field(cmd_field_names[k], want_rep.cmd[k], got_rep.cmd[k]);
          end
          check_field("lost_frames", want_rep.lost, got_rep.lost);
          check_field("command_fresh", want_rep.cmd_fresh, got_rep.cmd_fresh);
          check_field("link_fresh", want_rep.link_fresh, got_rep.link_fresh);
        end
      end
      // One long hold-off: let the block fill up and push back on the sender
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && reports_taken >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_gap != 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if (!tail_quiet && $urandom_range(99) < stall_pct) begin
        stall_gap = $urandom_range(10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic query, logic [7:0] b, logic [31:0] now);
    rx_item_t it;
    it.mode    = query;
    it.rx_byte = b;
    it.now_ms  = now;
    rx_backlog.push_back(it);
    items_queued++;
  endtask

  // Advance the link clock: mostly small steps, sometimes long silences or
  // arbitrary jumps (wraps and backward steps included)
  function automatic void tick_clock();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!ms_wander) ms_now++;
    else if (roll < 2) ms_now = $urandom();
    else if (roll < 6) ms_now += $urandom_range(3000);
    else ms_now += $urandom_range(3);
  endfunction

  // Queue one received byte, sometimes after a freshness query
  task automatic offer_byte(logic [7:0] b);
    if (ms_wander && $urandom_range(11) == 0) begin
      tick_clock();
      push_item(1'b1, 8'($urandom()), ms_now);
    end
    tick_clock();
    push_item(1'b0, b, ms_now);
  endtask

  // Wrap a header+payload in sync bytes and a little-endian CRC
  task automatic send_framed(logic [7:0] body[$], bit extra_sync, bit corrupt);
    logic [15:0] fcs;
    fcs = flr_pkg::CRC_INIT;
    foreach (body[i]) fcs = fcs_update(fcs, body[i]);
    if (corrupt) fcs ^= 16'h0001 << $urandom_range(15);
    if (extra_sync) offer_byte(flr_pkg::SYNC_FIRST);
    offer_byte(flr_pkg::SYNC_FIRST);
    offer_byte(flr_pkg::SYNC_SECOND);
    foreach (body[i]) offer_byte(body[i]);
    offer_byte(fcs[7:0]);
    offer_byte(fcs[15:8]);
  endtask

  // Mostly well-formed frames of every kind with random content; some noise,
  // oversized lengths and bad CRCs mixed in
  task automatic queue_random_frame();
    logic [7:0]  body[$];
    logic [7:0]  kind;
    logic [7:0]  len;
    int unsigned pick;
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 5)) offer_byte(8'($urandom()));
    end
    pick = $urandom_range(9);
    if (pick < 4) kind = link_cfg.cmd_type;
    else if (pick < 7) kind = link_cfg.hb_type;
    else kind = 8'($urandom());
    pick = $urandom_range(39);
    if (pick == 0) begin
      len = 8'($urandom());
    end else begin
      if (pick < 5) len = 8'd0;
      else if (pick < 17) len = 8'($urandom_range(1, 6));
      else len = 8'($urandom_range(7, 12));
      if (len > link_cfg.max_len) len = link_cfg.max_len;
    end
    // mostly in order; also gaps, duplicates and random jumps
    pick = $urandom_range(15);
    if (pick < 2) tx_seq += 8'($urandom_range(2, 6));
    else if (pick == 2) tx_seq = 8'($urandom());
    else if (pick != 3) tx_seq++;
    body = {8'($urandom()), kind, len, tx_seq};
    for (int i = 0; i < len; i++) begin
      body.push_back((i == 0 && $urandom_range(1) == 1) ? link_cfg.hb_src : 8'($urandom()));
    end
    send_framed(body, $urandom_range(5) == 0, $urandom_range(9) == 0);
  endtask

  // Wait on the falling edge so the driver and monitor have settled
  task automatic wait_drained();
    while (rx_backlog.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Setup-then-access register write; the register takes the value at the access edge
  task automatic write_reg(flr_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      flr_pkg::REG_CMD_TYPE:     link_cfg.cmd_type     = value[7:0];
      flr_pkg::REG_HB_TYPE:      link_cfg.hb_type      = value[7:0];
      flr_pkg::REG_HB_SRC:       link_cfg.hb_src       = value[7:0];
      flr_pkg::REG_MAX_LEN:      link_cfg.max_len      = value[7:0];
      flr_pkg::REG_CMD_TIMEOUT:  link_cfg.cmd_timeout  = value;
      flr_pkg::REG_LINK_TIMEOUT: link_cfg.link_timeout = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  body[$];
    logic [7:0]  same_type;
    int unsigned goal;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: query at reset, noise, repeated sync, a command frame with
    // extreme payload bytes, freshness at the timeout boundary across the
    // time wrap, then an oversized length
    push_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
    ms_now = 32'hFFFF_FE00;
    offer_byte(8'h00);
    body = {8'hFF, flr_pkg::CMD_TYPE_RST, 8'd7, 8'hFF,
            8'h80, 8'h7F, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01};
    send_framed(body, 1'b1, 1'b0);
    push_item(1'b1, 8'hFF, ms_now + 32'd499);
    ms_now += 32'd500;
    push_item(1'b1, 8'h00, ms_now);
    offer_byte(flr_pkg::SYNC_FIRST);
    offer_byte(flr_pkg::SYNC_SECOND);
    offer_byte(8'h01);
    offer_byte(flr_pkg::HB_TYPE_RST);
    offer_byte(8'hFF);
    ms_wander = 1'b1;

    for (int p = 1; p <= PHASE_COUNT; p++) begin
      wait_drained();
      case (p)
        1: begin
          // lower extremes: only empty frames fit, nothing is ever fresh
          write_reg(flr_pkg::REG_CMD_TYPE, 32'h00);
          write_reg(flr_pkg::REG_HB_TYPE, 32'hFF);
          write_reg(flr_pkg::REG_HB_SRC, 32'h00);
          write_reg(flr_pkg::REG_MAX_LEN, 32'h00);
          write_reg(flr_pkg::REG_CMD_TIMEOUT, 32'h0);
          write_reg(flr_pkg::REG_LINK_TIMEOUT, 32'h0);
        end
        2: begin
          // upper extremes
          write_reg(flr_pkg::REG_CMD_TYPE, 32'hFF);
          write_reg(flr_pkg::REG_HB_TYPE, 32'h00);
          write_reg(flr_pkg::REG_HB_SRC, 32'hFF);
          write_reg(flr_pkg::REG_MAX_LEN, 32'hFF);
          write_reg(flr_pkg::REG_CMD_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(flr_pkg::REG_LINK_TIMEOUT, 32'hFFFF_FFFF);
        end
        3: begin
          // command and heartbeat share a type: short commands act as heartbeats
          same_type = 8'($urandom());
          write_reg(flr_pkg::REG_CMD_TYPE, {24'h0, same_type});
          write_reg(flr_pkg::REG_HB_TYPE, {24'h0, same_type});
          write_reg(flr_pkg::REG_HB_SRC, $urandom_range(255));
          write_reg(flr_pkg::REG_MAX_LEN, $urandom_range(7, 40));
          write_reg(flr_pkg::REG_CMD_TIMEOUT, $urandom_range(20, 400));
          write_reg(flr_pkg::REG_LINK_TIMEOUT, $urandom_range(20, 800));
        end
        default: begin
          write_reg(flr_pkg::REG_CMD_TYPE, $urandom_range(255));
          write_reg(flr_pkg::REG_HB_TYPE, $urandom_range(255));
          write_reg(flr_pkg::REG_HB_SRC, $urandom_range(255));
          write_reg(flr_pkg::REG_MAX_LEN, $urandom_range(7, 80));
          write_reg(flr_pkg::REG_CMD_TIMEOUT, $urandom_range(1, 3000));
          write_reg(flr_pkg::REG_LINK_TIMEOUT, $urandom_range(1, 3000));
        end
      endcase
      @(negedge clk);
      // vary the idle mix per phase; drop all idling in the final phase
      send_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 10;
      stall_pct     = (p % 3 == 2) ? 0 : (p % 3 == 0) ? 30 : 15;
      tail_quiet    = (p == PHASE_COUNT);
      goal = items_queued + ITEMS_PER_PHASE;
      while (items_queued < goal) queue_random_frame();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/flr_pkg.sv
hdl/flr_cfg_regs.sv
hdl/flr_deframer.sv
hdl/flr_link_state.sv
hdl/framed_link_receiver.sv
hdl/flr_checker.sv
tb/framed_link_receiver_tb.sv
